/* sv/cmf_pkg.sv */
// Shared types and constants for the 3x3 weighted mean filter.
// No dependencies; every other file of the block imports it.
package cmf_pkg;

    localparam int PIX_W      = 8;
    localparam int OUT_W      = 12;
    localparam int DIM_W      = 11;
    localparam int COEF_W     = 36;
    localparam int TAP_W      = 4;
    localparam int TAPS       = 9;
    localparam int PROD_W     = 12;
    localparam int SUM_W      = 16;
    localparam int MUL_W      = 32;
    localparam int ROW_W      = 10;
    localparam int CFG_IDX_W  = 2;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_DIM       = 3;

    // floor(x / 9) == (x * DIV_MULT) >> DIV_SHIFT for every x below 2**16
    localparam int DIV_MULT  = 58255;
    localparam int DIV_SHIFT = 19;

    localparam int FIFO_DEPTH = 8;

    localparam logic [DIM_W-1:0]  DIM_RESET  = 11'd642;
    localparam logic [COEF_W-1:0] COEF_RESET = 36'h111111111;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF   = 2'd2;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } cmf_tag_t;

    typedef struct packed {
        logic     produce;
        cmf_tag_t tag;
    } cmf_ctl_t;

    typedef struct packed {
        logic [OUT_W-1:0] filtered;
        cmf_tag_t         tag;
    } cmf_result_t;

endpackage

/* sv/cmf_line_mem.sv */
// Two-row line buffer: one synchronous RAM entry per column holding {top, mid}.
// Registered read, with a bypass for a write to the address being read.
// Depends on cmf_pkg.
module cmf_line_mem #(
    parameter int DEPTH = cmf_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [2*cmf_pkg::PIX_W-1:0]  wr_data,
    output logic [2*cmf_pkg::PIX_W-1:0]  rd_data
);
    import cmf_pkg::*;

    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_q_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    logic               byp_sel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_sel_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_sel_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_sel_reg ? byp_data_reg : rd_q_reg;

endmodule

/* sv/cmf_window_mac.sv */
// 3x3 window, weighted tap products, sum and divide-by-9 pipeline.
// Each stage is registered and the pipeline has no stall. Depends on cmf_pkg.
module cmf_window_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  cmf_pkg::cmf_ctl_t             ctl,
    input  logic [cmf_pkg::PIX_W-1:0]     top,
    input  logic [cmf_pkg::PIX_W-1:0]     mid,
    input  logic [cmf_pkg::PIX_W-1:0]     px,
    input  logic [cmf_pkg::COEF_W-1:0]    coefficients,
    output logic                          res_valid,
    output cmf_pkg::cmf_result_t          res
);
    import cmf_pkg::*;

    logic [PIX_W-1:0]  win_reg [TAPS];
    logic [PROD_W-1:0] prod_reg [TAPS];
    logic [PROD_W-1:0] prod_next [TAPS];
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [MUL_W-1:0]  mul_reg, mul_next;
    logic              s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    cmf_tag_t          s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg;

    // rows 0..2 are top, mid, current; column 2 is the newest pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                win_reg[t] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[3*k]   <= win_reg[3*k+1];
                win_reg[3*k+1] <= win_reg[3*k+2];
            end
            win_reg[2] <= top;
            win_reg[5] <= mid;
            win_reg[8] <= px;
        end
    end

    always_comb
    begin
        for (int t = 0; t < TAPS; t++)
        begin
            prod_next[t] = PROD_W'(coefficients[TAP_W*t +: TAP_W]) * PROD_W'(win_reg[t]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int t = 0; t < TAPS; t++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[t]);
        end
    end

    assign mul_next = MUL_W'(sum_reg) * MUL_W'(DIV_MULT);

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        mul_reg    <= mul_next;
        s2_tag_reg <= ctl.tag;
        s3_tag_reg <= s2_tag_reg;
        s4_tag_reg <= s3_tag_reg;
        s5_tag_reg <= s4_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= shift_en && ctl.produce;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    assign res_valid    = s5_valid_reg;
    assign res.filtered = mul_reg[DIV_SHIFT +: OUT_W];
    assign res.tag      = s5_tag_reg;

endmodule

/* sv/cmf_out_fifo.sv */
// Result queue between the fixed-latency pipeline and the output channel.
// Space is reserved upstream, so a write never meets a full queue. Depends on cmf_pkg.
module cmf_out_fifo #(
    parameter int DEPTH = cmf_pkg::FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  cmf_pkg::cmf_result_t  wr_data,
    input  logic                  rd_en,
    output logic                  rd_valid,
    output cmf_pkg::cmf_result_t  rd_data
);
    import cmf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmf_result_t    buf_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rd_valid = (count_reg != '0);
    assign rd_data  = buf_reg[rd_ptr_reg];

endmodule

/* sv/conv3x3_mean_filter.sv */
// 3x3 weighted mean filter over a border-padded 8-bit raster stream.
// Top level: counters, configuration registers and credit control.
// Depends on cmf_pkg, cmf_line_mem, cmf_window_mac and cmf_out_fifo.
//
// Usage:
//   Pixels enter on in_valid/in_ready with frame_start set on row 0, column 0.
//   Each pixel whose 3x3 window is centred on an interior pixel (row >= 2 and
//   column >= 2 of the padded frame) yields one item on out_valid/out_ready:
//   the coefficient-weighted sum over nine taps divided by 9, with row_end on
//   the last item of a row and frame_end on the last item of the frame.
//   Configuration is written on cfg_valid/cfg_ready (always ready), index 0
//   width, 1 height, 2 packed coefficients, while the block is idle.
// Timing:
//   One pixel per clock sustained. A result passes the line buffer RAM read,
//   then window shift, tap products, sum, and the reciprocal multiply
//   before it is written to the output queue.
//   The eight-entry output queue is reserved at accept time; when the receiver
//   stalls and eight results are queued or in flight, in_ready drops.
// Reset:
//   Counters, window and queue clear; registers return to 642 x 642 with all
//   coefficients one. The line buffer RAM is not cleared and needs no sweep.
module conv3x3_mean_filter #(
    parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cmf_pkg::PIX_W-1:0]        pixel,
    input  logic                             frame_start,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cmf_pkg::OUT_W-1:0]        filtered,
    output logic                             row_end,
    output logic                             frame_end,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmf_pkg::COEF_W-1:0]       cfg_data
);
    import cmf_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WA_W  = $clog2(MAX_WIDTH + 1);
    localparam int WCW   = (WA_W > DIM_W) ? WA_W : DIM_W;
    localparam int CR_W  = $clog2(FIFO_DEPTH + 1);

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [COEF_W-1:0] coef_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CR_W-1:0]   credit_reg, credit_next;

    logic [WCW-1:0]    w_ext, w_clamped, c_ext;
    logic [DIM_W-1:0]  h_clamped, r_ext;
    logic [COL_W-1:0]  c_cur;
    logic [ROW_W-1:0]  r_cur;
    logic              in_fire, out_fire, last_col;
    cmf_ctl_t          ctl_cur;

    logic                 s1_valid_reg;
    cmf_ctl_t             s1_ctl_reg;
    logic [PIX_W-1:0]     s1_px_reg;
    logic [COL_W-1:0]     s1_addr_reg;
    logic [2*PIX_W-1:0]   rd_data;
    logic                 res_valid;
    cmf_result_t          res, head;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (credit_reg < CR_W'(FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            coef_reg   <= COEF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_COEF:   coef_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // clamp width to 3..MAX_WIDTH and height to 3..MAX_HEIGHT
    always_comb
    begin
        w_ext = WCW'(width_reg);
        if (w_ext < WCW'(MIN_DIM))
        begin
            w_clamped = WCW'(MIN_DIM);
        end
        else if (w_ext > WCW'(MAX_WIDTH))
        begin
            w_clamped = WCW'(MAX_WIDTH);
        end
        else
        begin
            w_clamped = w_ext;
        end
        if (height_reg < DIM_W'(MIN_DIM))
        begin
            h_clamped = DIM_W'(MIN_DIM);
        end
        else if (height_reg > DIM_W'(MAX_HEIGHT))
        begin
            h_clamped = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_clamped = height_reg;
        end
    end

    always_comb
    begin
        c_cur    = frame_start ? '0 : col_reg;
        r_cur    = frame_start ? '0 : row_reg;
        c_ext    = WCW'(c_cur);
        r_ext    = DIM_W'(r_cur);
        last_col = (c_ext == w_clamped - 1'b1);
        ctl_cur.produce       = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
        ctl_cur.tag.row_end   = last_col;
        ctl_cur.tag.frame_end = last_col && (r_ext == h_clamped - 1'b1);

        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (c_ext + 1'b1 >= w_clamped)
            begin
                col_next = '0;
                row_next = (r_ext + 1'b1 >= h_clamped) ? '0 : r_cur + 1'b1;
            end
            else
            begin
                col_next = c_cur + 1'b1;
                row_next = r_cur;
            end
        end

        credit_next = credit_reg;
        if ((in_fire && ctl_cur.produce) && !out_fire)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!(in_fire && ctl_cur.produce) && out_fire)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            credit_reg   <= credit_next;
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ctl_reg  <= ctl_cur;
            s1_px_reg   <= pixel;
            s1_addr_reg <= c_cur;
        end
    end

    // move mid up to top and store the new pixel as mid for this column
    cmf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (c_cur),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({rd_data[PIX_W-1:0], s1_px_reg}),
        .rd_data (rd_data)
    );

    cmf_window_mac u_window_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .shift_en     (s1_valid_reg),
        .ctl          (s1_ctl_reg),
        .top          (rd_data[2*PIX_W-1:PIX_W]),
        .mid          (rd_data[PIX_W-1:0]),
        .px           (s1_px_reg),
        .coefficients (coef_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    cmf_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_valid),
        .wr_data  (res),
        .rd_en    (out_fire),
        .rd_valid (out_valid),
        .rd_data  (head)
    );

    assign filtered  = head.filtered;
    assign row_end   = head.tag.row_end;
    assign frame_end = head.tag.frame_end;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CR_W'(FIFO_DEPTH))
        else $error("credit count exceeds output queue depth");

    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (credit_reg != '0))
        else $error("queued result without reserved credit");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && frame_start) |=> (col_reg == COL_W'(1)) && (row_reg == '0))
        else $error("frame start did not restart counters");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ctl_cur.produce) |-> ##5 res_valid)
        else $error("result did not leave pipeline on schedule");

endmodule
